@@ rtl/core/pfnl_pkg.sv @@
// Shared types and constants for the pocket floppy nibble link.
package pfnl_pkg;

  // Outgoing byte queue; depth must be a power of two.
  localparam int unsigned TxqDepth = 512;
  localparam int unsigned TxqAw    = $clog2(TxqDepth);
  localparam int unsigned TxqCntW  = $clog2(TxqDepth + 1);

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgDevCode  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartMs  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBitGapMs = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgAckMs    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSendMs   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgIdleMs   = 3'd5;

  // Configuration reset values.
  localparam logic [7:0] DevCodeRst  = 8'h41;
  localparam logic [7:0] StartMsRst  = 8'd40;
  localparam logic [7:0] BitGapMsRst = 8'd2;
  localparam logic [7:0] AckMsRst    = 8'd9;
  localparam logic [7:0] SendMsRst   = 8'd5;
  localparam logic [7:0] IdleMsRst   = 8'd50;

  localparam logic [7:0] MsSat = 8'hFF;

  // Item kinds.
  localparam logic KindSample  = 1'b0;
  localparam logic KindEnqueue = 1'b1;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StHold  = 6'b000010,
    StCode  = 6'b000100,
    StGap   = 6'b001000,
    StMatch = 6'b010000,
    StPulse = 6'b100000
  } hs_state_e;

  typedef struct packed {
    logic [7:0] dev_code;
    logic [7:0] start_ms;
    logic [7:0] bit_gap_ms;
    logic [7:0] ack_ms;
    logic [7:0] send_ms;
    logic [7:0] idle_ms;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic       ms_tick;
    logic       busy;
    logic       motor;
    logic       dout;
    logic       din;
    logic       sel1;
    logic       sel2;
    logic [7:0] out_byte;
  } item_t;

  // Queue requests from the link control.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } txq_req_t;

  // Queue status toward the link control.
  typedef struct packed {
    logic [TxqCntW-1:0] count;
    logic [TxqCntW-1:0] count_next;
    logic [7:0]         head_byte;
  } txq_sts_t;

  typedef struct packed {
    logic       ack;
    logic [3:0] drive_nibble;
    logic       nibble_sent;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       command_end;
    logic       code_valid;
    logic [7:0] code_value;
    logic       enqueue_dropped;
  } result_t;

endpackage

@@ rtl/core/pocket_floppy_nibble_link.sv @@
// Top level of the pocket floppy nibble link, device side.
//
// Usage:
//  - Slave stream (s_axis_*): one item per transfer. tuser picks the kind:
//    0 is a pin sample (tick and line levels), 1 queues out_byte for sending.
//  - Master stream (m_axis_*): exactly one result per accepted item, in order.
//  - Config channel (cfg_*): writes one 8-bit register by index; always ready.
//    Write only while no item is in flight.
// Timing and throughput: a result is registered and shows up in the cycle
// after its item's transfer; one item per cycle while m_axis_tready is high.
// The rate is set by the single step of control logic and the queue memory,
// whose head byte is prefetched (a write to that slot is forwarded).
// Stall: the output register holds the result while m_axis_tready is low;
// the slave side keeps taking items as long as the output register is empty
// or being drained in the same cycle.
// Reset (rst_ni low, asynchronous): handshake back to idle, all flags and
// counters cleared, queue empty, config registers at their defaults. The
// queue memory needs no clearing; only slots already written are read.
module pocket_floppy_nibble_link (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] ms_tick, [1] busy_in, [2] motor_out_in, [3] dout_in, [4] din_in,
  // [5] sel1_in, [6] sel2_in, [14:7] out_byte, [15] zero
  input  logic [pfnl_pkg::InDataW-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                          s_axis_tuser,
  // Results
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] ack_out, [4:1] drive_nibble, [5] nibble_sent, [6] rx_valid,
  // [14:7] rx_byte, [15] command_end, [16] code_valid, [24:17] code_value,
  // [25] enqueue_dropped, [35:26] queue_level, [39:36] zero
  output logic [pfnl_pkg::OutDataW-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pfnl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);

  pfnl_pkg::cfg_t     cfg_q;
  pfnl_pkg::item_t    item;
  pfnl_pkg::txq_req_t txq_req;
  pfnl_pkg::txq_sts_t txq_sts;
  pfnl_pkg::result_t  res;

  logic                          fire;
  logic                          out_valid_q;
  logic [pfnl_pkg::OutDataW-1:0] out_data_q;
  logic [pfnl_pkg::OutDataW-1:0] out_data_d;

  // Config registers; every transfer is taken, unknown indexes are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_code   <= pfnl_pkg::DevCodeRst;
      cfg_q.start_ms   <= pfnl_pkg::StartMsRst;
      cfg_q.bit_gap_ms <= pfnl_pkg::BitGapMsRst;
      cfg_q.ack_ms     <= pfnl_pkg::AckMsRst;
      cfg_q.send_ms    <= pfnl_pkg::SendMsRst;
      cfg_q.idle_ms    <= pfnl_pkg::IdleMsRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pfnl_pkg::CfgDevCode:  cfg_q.dev_code   <= cfg_data_i;
        pfnl_pkg::CfgStartMs:  cfg_q.start_ms   <= cfg_data_i;
        pfnl_pkg::CfgBitGapMs: cfg_q.bit_gap_ms <= cfg_data_i;
        pfnl_pkg::CfgAckMs:    cfg_q.ack_ms     <= cfg_data_i;
        pfnl_pkg::CfgSendMs:   cfg_q.send_ms    <= cfg_data_i;
        pfnl_pkg::CfgIdleMs:   cfg_q.idle_ms    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input item.
  assign item.kind     = s_axis_tuser;
  assign item.ms_tick  = s_axis_tdata[0];
  assign item.busy     = s_axis_tdata[1];
  assign item.motor    = s_axis_tdata[2];
  assign item.dout     = s_axis_tdata[3];
  assign item.din      = s_axis_tdata[4];
  assign item.sel1     = s_axis_tdata[5];
  assign item.sel2     = s_axis_tdata[6];
  assign item.out_byte = s_axis_tdata[14:7];

  // Accept whenever the output register is free or drains this cycle.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;

  pfnl_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .cfg_i  (cfg_q),
    .txq_i  (txq_sts),
    .txq_o  (txq_req),
    .res_o  (res)
  );

  pfnl_txq u_txq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (txq_req),
    .sts_o  (txq_sts)
  );

  assign out_data_d = {4'd0,
                       10'(txq_sts.count_next),
                       res.enqueue_dropped,
                       res.code_value,
                       res.code_valid,
                       res.command_end,
                       res.rx_byte,
                       res.rx_valid,
                       res.nibble_sent,
                       res.drive_nibble,
                       res.ack};

  // Output register: the payload only loads on an input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ rtl/core/pfnl_txq.sv @@
// Outgoing byte queue: one memory, head byte prefetched into a register.
module pfnl_txq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfnl_pkg::txq_req_t req_i,
  output pfnl_pkg::txq_sts_t sts_o
);

  logic [7:0]                  mem_q [pfnl_pkg::TxqDepth];
  logic [pfnl_pkg::TxqAw-1:0]  head_q, head_d;
  logic [pfnl_pkg::TxqCntW-1:0] count_q, count_d;
  logic [pfnl_pkg::TxqAw-1:0]  waddr;
  logic [7:0]                  rd_q;
  logic [7:0]                  wdata_q;
  logic                        fwd_q;

  assign waddr = head_q + count_q[pfnl_pkg::TxqAw-1:0];

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (req_i.push) begin
      count_d = count_q + 1'b1;
    end else if (req_i.pop) begin
      head_d  = head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
  end

  // Read the next head every cycle; a write to that same slot is forwarded.
  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[waddr] <= req_i.wdata;
    end
    rd_q    <= mem_q[head_d];
    wdata_q <= req_i.wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      fwd_q   <= req_i.push && (waddr == head_d);
    end
  end

  assign sts_o.count      = count_q;
  assign sts_o.count_next = count_d;
  assign sts_o.head_byte  = fwd_q ? wdata_q : rd_q;

endmodule

@@ rtl/core/pfnl_ctrl.sv @@
// Link control: start handshake, device code shifter, nibble receive and send.
module pfnl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  pfnl_pkg::item_t    item_i,
  input  pfnl_pkg::cfg_t     cfg_i,
  input  pfnl_pkg::txq_sts_t txq_i,
  output pfnl_pkg::txq_req_t txq_o,
  output pfnl_pkg::result_t  res_o
);

  pfnl_pkg::hs_state_e step_q, step_d;
  logic       prev_busy_q, prev_busy_d;
  logic       ack_q, ack_d;
  logic [7:0] ms_q, ms_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] bitcnt_q, bitcnt_d;
  logic [7:0] code_q, code_d;
  logic [3:0] rxlo_q, rxlo_d;
  logic       rxhalf_q, rxhalf_d;
  logic       rxpend_q, rxpend_d;
  logic       txhalf_q, txhalf_d;
  logic [3:0] drv_q, drv_d;

  logic       rise, fall, full;
  logic [3:0] nib;

  assign rise = item_i.busy && !prev_busy_q;
  assign fall = !item_i.busy && prev_busy_q;
  assign full = (txq_i.count == pfnl_pkg::TxqCntW'(pfnl_pkg::TxqDepth));
  assign nib  = {item_i.din, item_i.dout, item_i.sel2, item_i.sel1};

  always_comb begin
    step_d      = step_q;
    prev_busy_d = prev_busy_q;
    ack_d       = ack_q;
    ms_d        = ms_q;
    shift_d     = shift_q;
    bitcnt_d    = bitcnt_q;
    code_d      = code_q;
    rxlo_d      = rxlo_q;
    rxhalf_d    = rxhalf_q;
    rxpend_d    = rxpend_q;
    txhalf_d    = txhalf_q;
    drv_d       = drv_q;
    txq_o       = '0;
    txq_o.wdata = item_i.out_byte;
    res_o       = '0;

    if (fire_i) begin
      if (item_i.kind == pfnl_pkg::KindEnqueue) begin
        txq_o.push            = !full;
        res_o.enqueue_dropped = full;
      end else begin
        if (item_i.ms_tick && (ms_q != pfnl_pkg::MsSat)) begin
          ms_d = ms_q + 8'd1;
        end

        unique case (step_q)
          pfnl_pkg::StIdle: begin
            if (item_i.motor && item_i.dout) begin
              ms_d   = '0;
              step_d = pfnl_pkg::StHold;
            end
          end
          pfnl_pkg::StHold: begin
            if (item_i.motor && item_i.dout) begin
              if (ms_d > cfg_i.start_ms) begin
                step_d = pfnl_pkg::StCode;
                ack_d  = 1'b1;
              end
            end else begin
              step_d = pfnl_pkg::StIdle;
            end
          end
          pfnl_pkg::StCode: begin
            if (item_i.busy) begin
              shift_d  = {item_i.dout, shift_q[7:1]};
              bitcnt_d = bitcnt_q + 3'd1;
              ack_d    = 1'b0;
              if (bitcnt_d == 3'd0) begin
                code_d           = shift_d;
                res_o.code_valid = 1'b1;
                step_d = (shift_d == cfg_i.dev_code) ? pfnl_pkg::StMatch : pfnl_pkg::StIdle;
              end else begin
                step_d = pfnl_pkg::StGap;
                ms_d   = '0;
              end
            end
          end
          pfnl_pkg::StGap: begin
            if (ms_d > cfg_i.bit_gap_ms) begin
              step_d = pfnl_pkg::StCode;
              ack_d  = 1'b1;
            end
          end
          pfnl_pkg::StMatch: begin
            if (!item_i.busy && !item_i.motor) begin
              ack_d    = 1'b1;
              step_d   = pfnl_pkg::StPulse;
              ms_d     = '0;
              shift_d  = '0;
              bitcnt_d = '0;
            end
          end
          pfnl_pkg::StPulse: begin
            if (ms_d > cfg_i.ack_ms) begin
              ack_d  = 1'b0;
              step_d = pfnl_pkg::StIdle;
            end
          end
          default: step_d = pfnl_pkg::StIdle;
        endcase

        // Data phase.
        if ((code_d == cfg_i.dev_code) && (step_d == pfnl_pkg::StIdle)) begin
          priority if ((code_d != '0) && rise && !ack_d) begin
            if (rxhalf_q) begin
              res_o.rx_byte  = {nib, rxlo_q};
              res_o.rx_valid = 1'b1;
              rxhalf_d       = 1'b0;
            end else begin
              rxlo_d   = nib;
              rxhalf_d = 1'b1;
            end
            rxpend_d = 1'b1;
            ack_d    = 1'b1;
            ms_d     = '0;
          end else if ((code_d != '0) && fall && ack_d) begin
            ack_d = 1'b0;
            ms_d  = '0;
          end else if ((txq_i.count != '0) && (ms_d > cfg_i.send_ms) && !item_i.busy
                       && !ack_d) begin
            if (txhalf_q) begin
              drv_d     = txq_i.head_byte[7:4];
              txq_o.pop = 1'b1;
              txhalf_d  = 1'b0;
            end else begin
              drv_d    = txq_i.head_byte[3:0];
              txhalf_d = 1'b1;
            end
            res_o.nibble_sent = 1'b1;
            ack_d             = 1'b1;
          end else if (ack_d && rise) begin
            ack_d = 1'b0;
          end else if ((ms_d > cfg_i.idle_ms) && rxpend_q) begin
            res_o.command_end = 1'b1;
            if (rxhalf_q) begin
              res_o.rx_valid = 1'b1;
              res_o.rx_byte  = {4'd0, rxlo_q};
              rxhalf_d       = 1'b0;
            end
            rxpend_d = 1'b0;
          end else begin
            // nothing due on this sample
          end
        end
        prev_busy_d = item_i.busy;
      end
    end

    res_o.ack          = ack_d;
    res_o.drive_nibble = drv_d;
    res_o.code_value   = code_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= pfnl_pkg::StIdle;
      prev_busy_q <= 1'b0;
      ack_q       <= 1'b0;
      ms_q        <= '0;
      shift_q     <= '0;
      bitcnt_q    <= '0;
      code_q      <= '0;
      rxlo_q      <= '0;
      rxhalf_q    <= 1'b0;
      rxpend_q    <= 1'b0;
      txhalf_q    <= 1'b0;
      drv_q       <= '0;
    end else begin
      step_q      <= step_d;
      prev_busy_q <= prev_busy_d;
      ack_q       <= ack_d;
      ms_q        <= ms_d;
      shift_q     <= shift_d;
      bitcnt_q    <= bitcnt_d;
      code_q      <= code_d;
      rxlo_q      <= rxlo_d;
      rxhalf_q    <= rxhalf_d;
      rxpend_q    <= rxpend_d;
      txhalf_q    <= txhalf_d;
      drv_q       <= drv_d;
    end
  end

endmodule

@@ dv/pfnl_checker.sv @@
// Scoreboard for the nibble link: mirrors the device logic and checks every result transfer.
module pfnl_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned fail_cnt_o,
  output int unsigned pend_cnt_o,
  output int unsigned codes_o,
  output int unsigned rx_bytes_o,
  output int unsigned cmd_ends_o,
  output int unsigned nibbles_o,
  output int unsigned drops_o
);
  import pfnl_pkg::*;

  // Result layout, msb first, so it casts straight from m_axis_tdata[35:0].
  typedef struct packed {
    logic [9:0] level;
    logic       dropped;
    logic [7:0] code_value;
    logic       code_valid;
    logic       cmd_end;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       sent;
    logic [3:0] nib;
    logic       ack;
  } link_result_t;

  // Mirror of the device state
  cfg_t               cfg_q;
  hs_state_e          hs_q;
  logic               busy_q, ack_q;
  logic [7:0]         ms_q, shift_q, dev_q;
  logic [2:0]         bits_q;
  logic [3:0]         rx_lo_q, nib_q;
  logic               rx_half_q, rx_pend_q, tx_half_q;
  logic [7:0]         txq_mem [TxqDepth];
  logic [TxqAw-1:0]   head_q;
  logic [TxqCntW-1:0] cnt_q;

  link_result_t awaited_results [$];
  link_result_t want, got;
  int unsigned  fail_n, codes_n, rx_n, ends_n, nib_n, drop_n;

  // One device step; updates the mirror and returns the result it produces.
  function automatic link_result_t next_link_result(input logic kind, input logic [15:0] d);
    link_result_t r;
    logic         tick, busy, motor, dout, din, sel1, sel2, rise, fall;
    logic [7:0]   obyte, b;
    logic [3:0]   nib;
    r = '0;
    {obyte, sel2, sel1, din, dout, motor, busy, tick} = d[14:0];
    if (kind == KindEnqueue) begin
      if (cnt_q < TxqDepth) begin
        txq_mem[TxqAw'(head_q + cnt_q)] = obyte;
        cnt_q = cnt_q + 1'b1;
      end else begin
        r.dropped = 1'b1;
      end
    end else begin
      rise = busy & ~busy_q;
      fall = ~busy & busy_q;
      if (tick && ms_q != MsSat) ms_q = ms_q + 8'd1;

      case (hs_q)
        StIdle: begin
          if (motor && dout) begin
            ms_q = '0;
            hs_q = StHold;
          end
        end
        StHold: begin
          if (motor && dout) begin
            if (ms_q > cfg_q.start_ms) begin
              hs_q  = StCode;
              ack_q = 1'b1;
            end
          end else begin
            hs_q = StIdle;
          end
        end
        StCode: begin
          if (busy) begin
            shift_q = {dout, shift_q[7:1]};
            bits_q  = bits_q + 3'd1;
            ack_q   = 1'b0;
            if (bits_q == 3'd0) begin
              dev_q        = shift_q;
              r.code_valid = 1'b1;
              hs_q         = (shift_q == cfg_q.dev_code) ? StMatch : StIdle;
            end else begin
              hs_q = StGap;
              ms_q = '0;
            end
          end
        end
        StGap: begin
          if (ms_q > cfg_q.bit_gap_ms) begin
            hs_q  = StCode;
            ack_q = 1'b1;
          end
        end
        StMatch: begin
          if (!busy && !motor) begin
            ack_q   = 1'b1;
            hs_q    = StPulse;
            ms_q    = '0;
            shift_q = '0;
            bits_q  = '0;
          end
        end
        StPulse: begin
          if (ms_q > cfg_q.ack_ms) begin
            ack_q = 1'b0;
            hs_q  = StIdle;
          end
        end
        default: hs_q = StIdle;
      endcase

      // data phase: priority is receive, release, send, host ack, idle end
      if (dev_q == cfg_q.dev_code && hs_q == StIdle) begin
        if (dev_q != 8'd0 && rise && !ack_q) begin
          nib = {din, dout, sel2, sel1};
          if (rx_half_q) begin
            r.rx_byte  = {nib, rx_lo_q};
            r.rx_valid = 1'b1;
            rx_half_q  = 1'b0;
          end else begin
            rx_lo_q   = nib;
            rx_half_q = 1'b1;
          end
          rx_pend_q = 1'b1;
          ack_q     = 1'b1;
          ms_q      = '0;
        end else if (dev_q != 8'd0 && fall && ack_q) begin
          ack_q = 1'b0;
          ms_q  = '0;
        end else if (cnt_q != '0 && ms_q > cfg_q.send_ms && !busy && !ack_q) begin
          b = txq_mem[head_q];
          if (tx_half_q) begin
            nib_q     = b[7:4];
            head_q    = head_q + 1'b1;
            cnt_q     = cnt_q - 1'b1;
            tx_half_q = 1'b0;
          end else begin
            nib_q     = b[3:0];
            tx_half_q = 1'b1;
          end
          r.sent = 1'b1;
          ack_q  = 1'b1;
        end else if (ack_q && rise) begin
          ack_q = 1'b0;
        end else if (ms_q > cfg_q.idle_ms && rx_pend_q) begin
          r.cmd_end = 1'b1;
          if (rx_half_q) begin
            r.rx_valid = 1'b1;
            r.rx_byte  = {4'h0, rx_lo_q};
            rx_half_q  = 1'b0;
          end
          rx_pend_q = 1'b0;
        end
      end
      busy_q = busy;
    end
    r.ack        = ack_q;
    r.nib        = nib_q;
    r.code_value = dev_q;
    r.level      = 10'(cnt_q);
    return r;
  endfunction

  task automatic cmp_field(input string name, input logic [9:0] exp_v, input logic [9:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, act_v);
      fail_n++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     = {DevCodeRst, StartMsRst, BitGapMsRst, AckMsRst, SendMsRst, IdleMsRst};
      hs_q      = StIdle;
      busy_q    = 1'b0;
      ack_q     = 1'b0;
      ms_q      = '0;
      shift_q   = '0;
      dev_q     = '0;
      bits_q    = '0;
      rx_lo_q   = '0;
      nib_q     = '0;
      rx_half_q = 1'b0;
      rx_pend_q = 1'b0;
      tx_half_q = 1'b0;
      head_q    = '0;
      cnt_q     = '0;
      awaited_results.delete();
      fail_n    = 0;
      codes_n   = 0;
      rx_n      = 0;
      ends_n    = 0;
      nib_n     = 0;
      drop_n    = 0;
    end else begin
      // results first: the one leaving now belongs to an earlier transfer
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer 'h%0h", m_axis_tdata);
          fail_n++;
        end else begin
          want = awaited_results.pop_front();
          got  = link_result_t'(m_axis_tdata[35:0]);
          cmp_field("ack_out",         10'(want.ack),        10'(got.ack));
          cmp_field("drive_nibble",    10'(want.nib),        10'(got.nib));
          cmp_field("nibble_sent",     10'(want.sent),       10'(got.sent));
          cmp_field("rx_valid",        10'(want.rx_valid),   10'(got.rx_valid));
          cmp_field("rx_byte",         10'(want.rx_byte),    10'(got.rx_byte));
          cmp_field("command_end",     10'(want.cmd_end),    10'(got.cmd_end));
          cmp_field("code_valid",      10'(want.code_valid), 10'(got.code_valid));
          cmp_field("code_value",      10'(want.code_value), 10'(got.code_value));
          cmp_field("enqueue_dropped", 10'(want.dropped),    10'(got.dropped));
          cmp_field("queue_level",     want.level,           got.level);
          cmp_field("tdata pad",       10'd0,                10'(m_axis_tdata[39:36]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = next_link_result(s_axis_tuser, s_axis_tdata);
        awaited_results.push_back(want);
        codes_n += want.code_valid;
        rx_n    += want.rx_valid;
        ends_n  += want.cmd_end;
        nib_n   += want.sent;
        drop_n  += want.dropped;
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgDevCode:  cfg_q.dev_code   = cfg_data_i;
          CfgStartMs:  cfg_q.start_ms   = cfg_data_i;
          CfgBitGapMs: cfg_q.bit_gap_ms = cfg_data_i;
          CfgAckMs:    cfg_q.ack_ms     = cfg_data_i;
          CfgSendMs:   cfg_q.send_ms    = cfg_data_i;
          CfgIdleMs:   cfg_q.idle_ms    = cfg_data_i;
          default: ;
        endcase
      end
    end
    fail_cnt_o <= fail_n;
    pend_cnt_o <= awaited_results.size();
    codes_o    <= codes_n;
    rx_bytes_o <= rx_n;
    cmd_ends_o <= ends_n;
    nibbles_o  <= nib_n;
    drops_o    <= drop_n;
  end

endmodule

@@ dv/tb.sv @@
// Top-level testbench for the nibble link: stimulus, back pressure and verdict.
module tb;
  import pfnl_pkg::*;

  // No transfer of any kind for this many cycles means the block hung.
  localparam int unsigned WatchdogLimit = 4000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [0] ms_tick, [1] busy, [2] motor, [3] dout, [4] din, [5] sel1, [6] sel2,
  // [14:7] out_byte, [15] zero
  logic [15:0] s_axis_tdata = '0;
  // [0] kind
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] ack, [4:1] nibble, [5] sent, [6] rx_valid, [14:7] rx_byte, [15] cmd end,
  // [16] code_valid, [24:17] code, [25] dropped, [35:26] queue level
  logic [39:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  int unsigned fail_cnt, pend_cnt, codes, rx_bytes, cmd_ends, nibbles, drops;
  int unsigned n_items, n_cfg, stall_cycles;
  int unsigned src_idle_pct, sink_idle_pct;
  logic        busy_lv;

  // Stimulus-side copy of the registers: the code to send and sequence sizes.
  logic [7:0]  st_match, st_start, st_gap, st_ack, st_send, st_idle;

  pocket_floppy_nibble_link uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  pfnl_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_cnt_o    (fail_cnt),
    .pend_cnt_o    (pend_cnt),
    .codes_o       (codes),
    .rx_bytes_o    (rx_bytes),
    .cmd_ends_o    (cmd_ends),
    .nibbles_o     (nibbles),
    .drops_o       (drops)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver back pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic coin();
    return logic'($urandom_range(1));
  endfunction

  // One input transfer. Valid only drops when the sender decides to idle,
  // so back-to-back items never see a low/high pair in the same step.
  task automatic put_item(input logic kind, input logic [15:0] data);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
  endtask

  // Pin sample; out_byte is don't-care here, so it gets random bits.
  task automatic pin_step(input logic tick, input logic busy, input logic motor,
                          input logic dout, input logic din, input logic sel1,
                          input logic sel2);
    put_item(KindSample, {1'b0, 8'($urandom), sel2, sel1, din, dout, motor, busy, tick});
  endtask

  task automatic enq(input logic [7:0] b);
    put_item(KindEnqueue, {1'b0, b, 7'($urandom)});
  endtask

  // Stop sending and wait for every outstanding result. Called right after
  // a transfer so valid is lowered in the step the last item went through.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pend_cnt != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Rewrites all six registers with the link drained.
  task automatic load_cfg(input logic [7:0] m, input logic [7:0] s, input logic [7:0] g,
                          input logic [7:0] a, input logic [7:0] snd, input logic [7:0] i);
    settle();
    cfg_put(CfgDevCode, m);
    cfg_put(CfgStartMs, s);
    cfg_put(CfgBitGapMs, g);
    cfg_put(CfgAckMs, a);
    cfg_put(CfgSendMs, snd);
    cfg_put(CfgIdleMs, i);
    cfg_valid_i <= 1'b0;
    {st_match, st_start, st_gap, st_ack, st_send, st_idle} = {m, s, g, a, snd, i};
    n_cfg++;
  endtask

  // Full opening handshake: start hold, eight code bits LSB first with
  // gaps, then the closing ack pulse. Only used with small timings.
  task automatic handshake(input logic [7:0] code);
    repeat (int'(st_start) + 2 + $urandom_range(2)) pin_step(1'b1, 1'b0, 1'b1, 1'b1, coin(),
                                                            coin(), coin());
    for (int i = 0; i < 8; i++) begin
      pin_step(coin(), 1'b1, coin(), code[i], coin(), coin(), coin());
      if (i < 7) begin
        repeat (int'(st_gap) + 1 + $urandom_range(1)) pin_step(1'b1, 1'b0, 1'b1, coin(),
                                                               coin(), coin(), coin());
      end
    end
    // busy and motor low start the pulse; hold the lines quiet until it ends
    repeat (int'(st_ack) + 2 + $urandom_range(1)) pin_step(1'b1, 1'b0, 1'b0, coin(), coin(),
                                                           coin(), coin());
    busy_lv = 1'b0;
  endtask

  // Data-phase traffic: busy toggling carries host nibbles and acks our
  // sends; mixed with enqueues, idle stretches, noise and drain pauses.
  task automatic traffic(input int unsigned n);
    int unsigned roll;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        enq(8'($urandom));
      end else if (roll < 11) begin
        busy_lv = 1'b0;
        repeat ((st_idle > 8'd40 ? 40 : int'(st_idle)) + 2) pin_step(1'b1, 1'b0, 1'b0, coin(),
                                                                    coin(), coin(), coin());
      end else if (roll < 16) begin
        put_item(KindSample, {1'b0, 15'($urandom)});
      end else if (roll < 17) begin
        settle();
      end else begin
        if ($urandom_range(99) < 60) busy_lv = ~busy_lv;
        pin_step($urandom_range(99) < 70, busy_lv, $urandom_range(99) < 5, coin(), coin(),
                 coin(), coin());
      end
    end
  endtask

  initial begin
    int unsigned stop_at;
    busy_lv       = 1'b0;
    n_items       = 0;
    n_cfg         = 0;
    src_idle_pct  = 28;
    sink_idle_pct = 62;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: default settings, no data phase yet (code register is zero).
    put_item(KindEnqueue, {1'b0, 8'hFF, 7'h7F});   // enqueue ignores all-high pins
    put_item(KindEnqueue, {1'b0, 8'h00, 7'h00});
    pin_step(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    pin_step(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1); // start lines high: hold begins
    pin_step(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    pin_step(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0); // dout drops: hold abandoned
    for (int i = 0; i < 7; i++) put_item(KindSample, {1'b0, 8'hA5, 7'(1 << i)});
    put_item(KindSample, {1'b0, 8'hFF, 7'h00});
    enq(8'h5A);
    settle();

    // Nonzero code, short timings.
    load_cfg(8'($urandom_range(1, 255)), 8'($urandom_range(0, 4)), 8'd1, 8'd2, 8'd2, 8'd8);
    handshake(st_match);
    // host nibbles 0x0, 0xF, 0xF on busy rises with releases between, then idle
    pin_step(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    pin_step(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    pin_step(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    pin_step(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    pin_step(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    pin_step(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    repeat (int'(st_idle) + 2) pin_step(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    stop_at = n_items + 40;
    while (n_items < stop_at) begin
      handshake(($urandom_range(99) < 85) ? st_match : 8'($urandom));
      traffic($urandom_range(10, 40));
    end

    // Zero code and all-zero timings: only sending, host-ack release and
    // command end are live once the code register reads zero.
    load_cfg(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    stop_at = n_items + 20;
    while (n_items < stop_at) begin
      handshake(($urandom_range(99) < 85) ? st_match : 8'($urandom));
      traffic($urandom_range(10, 40));
    end

    src_idle_pct  = 62;
    sink_idle_pct = 28;

    // Timer saturation: send gap and idle limit at 255 never expire.
    load_cfg(8'($urandom_range(1, 255)), 8'd1, 8'd0, 8'd1, 8'hFF, 8'hFF);
    handshake(st_match);
    repeat (3) begin
      pin_step(1'b1, 1'b1, 1'b0, coin(), coin(), coin(), coin());
      pin_step(1'b1, 1'b0, 1'b0, coin(), coin(), coin(), coin());
    end
    repeat (262) pin_step(1'b1, 1'b0, 1'b0, coin(), coin(), coin(), coin());

    // All registers at maximum: start hold can never complete.
    load_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    repeat (20) pin_step(1'b1, coin(), 1'b1, 1'b1, coin(), coin(), coin());
    repeat (20) put_item(1'($urandom_range(1)), {1'b0, 15'($urandom)});

    src_idle_pct  = 0;
    sink_idle_pct = 0;

    // Random moderate settings, no idling on either side.
    load_cfg(8'($urandom_range(1, 255)), 8'($urandom_range(0, 4)), 8'($urandom_range(0, 3)),
             8'($urandom_range(0, 4)), 8'($urandom_range(0, 6)), 8'($urandom_range(2, 12)));
    stop_at = n_items + 20;
    while (n_items < stop_at) begin
      handshake(($urandom_range(99) < 85) ? st_match : 8'($urandom));
      traffic($urandom_range(10, 40));
    end

    // Enqueues only, so nothing drains: the queue fills and refuses the rest.
    repeat (TxqDepth + 8) enq(8'($urandom));

    settle();
    repeat (6) @(posedge clk_i);
    $display("Ran %0d items over %0d register settings: %0d device codes, %0d bytes received,",
             n_items, n_cfg + 1, codes, rx_bytes);
    $display("%0d command ends, %0d nibbles sent and %0d enqueues refused on a full queue.",
             cmd_ends, nibbles, drops);
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ pocket_floppy_nibble_link.f @@
rtl/core/pfnl_pkg.sv
rtl/core/pfnl_txq.sv
rtl/core/pfnl_ctrl.sv
rtl/core/pocket_floppy_nibble_link.sv
dv/pfnl_checker.sv
dv/tb.sv
